/* hdl/lz4d_pkg.sv */
// Shared types and constants for the LZ4 block decoder.
package lz4d_pkg;

	localparam int WINDOW_DEPTH_DEF = 65536;

	localparam logic [3:0] LEN_MORE  = 4'hF;
	localparam logic [3:0] MIN_MATCH = 4'd4;
	localparam logic [7:0] EXT_CONT  = 8'hFF;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_DROPPED = 2'd1;
	localparam logic [1:0] ERR_OFFSET  = 2'd2;

	typedef enum logic [8:0] {
		PH_HEADER = 9'b000000001,
		PH_STORED = 9'b000000010,
		PH_TOKEN  = 9'b000000100,
		PH_LITEXT = 9'b000001000,
		PH_LIT    = 9'b000010000,
		PH_OFF0   = 9'b000100000,
		PH_OFF1   = 9'b001000000,
		PH_MATEXT = 9'b010000000,
		PH_COPY   = 9'b100000000
	} phase_t;

	typedef struct packed {
		logic       action;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        copy_pending;
		logic        block_done;
		logic [31:0] decoded_size;
		logic [1:0]  error_code;
	} out_item_t;

endpackage

/* hdl/lz4d_hist.sv */
// History ring memory with registered read and write-to-read bypass.
module lz4d_hist #(
	parameter int DEPTH = lz4d_pkg::WINDOW_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [DEPTH];
	logic [7:0] rd_q;
	logic [7:0] wd_q;
	logic       byp_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
		wd_q <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= we && (raddr == waddr);
		end
	end

	assign rdata = byp_q ? wd_q : rd_q;
endmodule

/* hdl/lz4_block_decoder_core.sv */
// Top level of the LZ4 block decoder: input register, decode logic, result register.
//
//   channel | signals                          | beat
//   input   | in_valid, in_ready, in_data      | one compressed byte or one copy tick
//   output  | out_valid, out_ready, out_data   | one result per input beat
//
// Each beat passes from the input register through the decode stage into the result register.
// The history ring is read ahead from the next decode state, with a bypass for a
// byte written in the same cycle, so a copy tick may follow any beat directly.
// Reset clears all control state; history contents are undefined until written.
// A stall on the output holds both stages; the input stays ready while a stage is free.
module lz4_block_decoder_core #(
	parameter int WINDOW_DEPTH = lz4d_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lz4d_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lz4d_pkg::out_item_t out_data
);
	import lz4d_pkg::*;

	localparam int AW = $clog2(WINDOW_DEPTH);

	in_item_t  in_s1;
	logic      s1_v_q;
	out_item_t out_q;
	logic      out_v_q;
	logic      adv;
	logic      go;

	phase_t      ph_q, ph_d;
	logic [1:0]  hidx_q, hidx_d;
	logic        stored_q, stored_d;
	logic [30:0] cl_q, cl_d;
	logic [31:0] lit_q, lit_d;
	logic [3:0]  mn_q, mn_d;
	logic [31:0] ml_q, ml_d;
	logic [15:0] dist_q, dist_d;
	logic [AW-1:0] wp_q, wp_d;
	logic [31:0] prod_q, prod_d, prod_out;

	logic        emit, fin, done;
	logic [1:0]  err;
	logic [7:0]  ebyte, b, rdata;
	logic [30:0] rem, cl3;
	logic [32:0] lit_sum;
	logic [33:0] ml_sum;
	logic        bad;
	logic [17:0] ra_t;
	logic [AW-1:0] raddr;
	out_item_t   res;

	assign adv      = !out_v_q || out_ready;
	assign go       = s1_v_q && adv;
	assign in_ready = !s1_v_q || adv;
	assign b        = in_s1.in_byte;

	always_comb begin
		ph_d = ph_q; hidx_d = hidx_q; stored_d = stored_q; cl_d = cl_q;
		lit_d = lit_q; mn_d = mn_q; ml_d = ml_q; dist_d = dist_q;
		wp_d = wp_q; prod_d = prod_q;
		emit = 1'b0; fin = 1'b0; err = ERR_NONE; ebyte = b; bad = 1'b0;
		rem = cl_q - 31'd1;
		cl3 = cl_q | {b[6:0], 24'd0};
		lit_sum = {1'b0, lit_q} + {25'd0, b};
		ml_sum = {2'b0, ml_q} + {26'd0, b} + ((b != EXT_CONT) ? 34'(MIN_MATCH) : 34'd0);
		if (go) begin
			if (!in_s1.action) begin
				if (ph_q != PH_HEADER && ph_q != PH_COPY) begin
					cl_d = rem;
				end
				case (ph_q)
					PH_COPY: begin
						err = ERR_DROPPED;
					end
					PH_HEADER: begin
						case (hidx_q)
							2'd0: begin
								cl_d = {23'd0, b}; stored_d = 1'b0; hidx_d = 2'd1;
							end
							2'd1: begin
								cl_d = cl_q | {15'd0, b, 8'd0}; hidx_d = 2'd2;
							end
							2'd2: begin
								cl_d = cl_q | {7'd0, b, 16'd0}; hidx_d = 2'd3;
							end
							default: begin
								cl_d = cl3; stored_d = b[7]; hidx_d = 2'd0;
								if (cl3 == 31'd0) fin = 1'b1;
								else ph_d = b[7] ? PH_STORED : PH_TOKEN;
							end
						endcase
					end
					PH_STORED: begin
						emit = 1'b1;
						if (rem == 31'd0) fin = 1'b1;
					end
					PH_TOKEN: begin
						lit_d = {28'd0, b[7:4]};
						mn_d = b[3:0];
						if (rem == 31'd0) fin = 1'b1;
						else if (b[7:4] == 4'd0) ph_d = PH_OFF0;
						else ph_d = (b[7:4] == LEN_MORE) ? PH_LITEXT : PH_LIT;
					end
					PH_LITEXT: begin
						lit_d = lit_sum[32] ? 32'hFFFF_FFFF : lit_sum[31:0];
						if (rem == 31'd0) fin = 1'b1;
						else if (b != EXT_CONT) ph_d = PH_LIT;
					end
					PH_LIT: begin
						emit = 1'b1;
						lit_d = lit_q - 32'd1;
						if (rem == 31'd0) fin = 1'b1;
						else if (lit_q == 32'd1) ph_d = PH_OFF0;
					end
					PH_OFF0: begin
						dist_d = {8'd0, b};
						if (rem == 31'd0) fin = 1'b1;
						else ph_d = PH_OFF1;
					end
					PH_OFF1: begin
						dist_d = {b, dist_q[7:0]};
						if (mn_q == LEN_MORE) begin
							ml_d = 32'(LEN_MORE);
							if (rem == 31'd0) fin = 1'b1;
							else ph_d = PH_MATEXT;
						end else begin
							ml_d = 32'(mn_q) + 32'(MIN_MATCH);
							bad = 1'b1;
						end
					end
					PH_MATEXT: begin
						ml_d = (ml_sum[33:32] != 2'd0) ? 32'hFFFF_FFFF : ml_sum[31:0];
						if (b == EXT_CONT) begin
							if (rem == 31'd0) fin = 1'b1;
						end else begin
							bad = 1'b1;
						end
					end
					default: begin
						ph_d = PH_HEADER;
					end
				endcase
				if (bad) begin
					if (dist_d == 16'd0 || 32'(dist_d) > prod_q ||
					    {1'b0, dist_d} > 17'(WINDOW_DEPTH)) begin
						err = ERR_OFFSET;
						ml_d = 32'd0;
						if (rem == 31'd0) fin = 1'b1;
						else ph_d = PH_TOKEN;
					end else begin
						ph_d = PH_COPY;
					end
				end
			end else if (ph_q == PH_COPY) begin
				emit = 1'b1;
				ebyte = rdata;
				ml_d = ml_q - 32'd1;
				if (ml_q == 32'd1) begin
					if (cl_q == 31'd0) fin = 1'b1;
					else ph_d = PH_TOKEN;
				end
			end
		end
		if (emit) begin
			wp_d = (wp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + AW'(1);
			prod_d = (prod_q == 32'hFFFF_FFFF) ? prod_q : prod_q + 32'd1;
		end
		done = fin;
		if (fin) begin
			ph_d = PH_HEADER; hidx_d = 2'd0; stored_d = 1'b0;
			cl_d = '0; lit_d = '0; ml_d = '0;
		end
		prod_out = prod_d;
		if (fin) prod_d = '0;
		res.out_byte     = emit ? ebyte : 8'd0;
		res.byte_valid   = emit;
		res.copy_pending = (ph_d == PH_COPY);
		res.block_done   = done;
		res.decoded_size = prod_out;
		res.error_code   = err;
	end

	always_comb begin
		ra_t = 18'(wp_d) + 18'(WINDOW_DEPTH) - 18'(dist_d);
		if (ra_t >= 18'(WINDOW_DEPTH)) ra_t = ra_t - 18'(WINDOW_DEPTH);
		raddr = ra_t[AW-1:0];
	end

	lz4d_hist #(.DEPTH(WINDOW_DEPTH), .AW(AW)) u_hist (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (go && emit),
		.waddr (wp_q),
		.wdata (ebyte),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_HEADER; hidx_q <= '0; stored_q <= 1'b0; cl_q <= '0;
			lit_q <= '0; mn_q <= '0; ml_q <= '0; dist_q <= '0;
			wp_q <= '0; prod_q <= '0;
			s1_v_q <= 1'b0; out_v_q <= 1'b0;
		end else begin
			ph_q <= ph_d; hidx_q <= hidx_d; stored_q <= stored_d; cl_q <= cl_d;
			lit_q <= lit_d; mn_q <= mn_d; ml_q <= ml_d; dist_q <= dist_d;
			wp_q <= wp_d; prod_q <= prod_d;
			if (in_ready) s1_v_q <= in_valid;
			if (adv) out_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) in_s1 <= in_data;
		if (go) out_q <= res;
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	a_copy_len: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_COPY |-> ml_q != 32'd0) else $error("copy phase with zero match length");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q.block_done |-> !out_q.copy_pending)
		else $error("block done while copy pending");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && !adv |=> s1_v_q && $stable(in_s1)) else $error("stalled item lost");
	a_prod_clr: assert property (@(posedge clk) disable iff (!arst_n)
		go && done |=> prod_q == 32'd0) else $error("produced count not cleared");
endmodule
